/* rtl/adu_pkg.sv */
// adu_pkg: shared types and constants of the Adam update block.
// Used by adu_front, adu_queue, adu_back and adam_update.
package adu_pkg;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEARNING_RATE = 3'd0,
    CFG_BETA_ONE      = 3'd1,
    CFG_BETA_TWO      = 3'd2,
    CFG_EPSILON       = 3'd3,
    CFG_GRAD_SCALE    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/adam_update.sv */
// adam_update: top level of the fixed-point Adam update block.
// Instantiates adu_front, adu_queue and adu_back; depends on adu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one parameter element per transaction
//   with its gradient and both stored moments; first_of_step marks the first
//   element of a training step. Output channel (out_valid / out_stall): one
//   result per input, in order: new value, both moments, scaled gradient and
//   a saturation flag. Config channel (cfg_valid / cfg_ready, always ready):
//   writes register cfg_index with cfg_data; write only while the block idles.
//   Throughput: one element per cycle when nothing stalls. An element with
//   first_of_step set is held while the front updates the beta powers and
//   recomputes the corrected rate with its iterative square root and divider.
//   Elements pass through the queue and the back pipeline, whose square root
//   and divider pipelines resolve one bit per stage.
//   out_stall freezes the whole back pipeline; the four-entry queue keeps
//   taking inputs until it fills. Reset restores the register defaults,
//   sets both beta powers to one and the corrected rate to zero.
module adam_update #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 first_of_step,
  input  logic signed [DATA_WIDTH-1:0]         param_value,
  input  logic signed [DATA_WIDTH-1:0]         grad_in,
  input  logic signed [DATA_WIDTH-1:0]         first_moment,
  input  logic [DATA_WIDTH-2:0]                second_moment,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [DATA_WIDTH-1:0]         new_value,
  output logic signed [DATA_WIDTH-1:0]         new_first_moment,
  output logic [DATA_WIDTH-2:0]                new_second_moment,
  output logic signed [DATA_WIDTH-1:0]         scaled_gradient,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adu_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data
);
  import adu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int QW = 5*W - 1;
  localparam longint unsigned ONE_Q   = 64'd1 << F;
  localparam longint unsigned LR_RST  = (ONE_Q + 64'd500) / 64'd1000;
  localparam longint unsigned B1_RST  = (ONE_Q * 64'd900 + 64'd500) / 64'd1000;
  localparam longint unsigned B2_RST  = (ONE_Q * 64'd999 + 64'd500) / 64'd1000;

  logic [W-2:0] learning_rate;
  logic [F-1:0] beta_one;
  logic [F-1:0] beta_two;
  logic [W-2:0] epsilon_term;
  logic [W-2:0] gradient_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate  <= (W-1)'(LR_RST);
      beta_one       <= F'(B1_RST);
      beta_two       <= F'(B2_RST);
      epsilon_term   <= (W-1)'(1);
      gradient_scale <= (W-1)'(ONE_Q);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LEARNING_RATE: learning_rate  <= cfg_data[W-2:0];
        CFG_BETA_ONE:      beta_one       <= cfg_data[F-1:0];
        CFG_BETA_TWO:      beta_two       <= cfg_data[F-1:0];
        CFG_EPSILON:       epsilon_term   <= cfg_data[W-2:0];
        CFG_GRAD_SCALE:    gradient_scale <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  queue_status_t qs;
  logic          push, pop;
  logic [W-2:0]  rate;
  logic          rate_sat;
  logic [QW-1:0] wdata, rdata;

  adu_front #(.W(W), .F(F)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .first_of_step (first_of_step),
    .in_stall      (in_stall),
    .learning_rate (learning_rate),
    .beta_one      (beta_one),
    .beta_two      (beta_two),
    .qs            (qs),
    .push          (push),
    .rate          (rate),
    .rate_sat      (rate_sat)
  );

  assign wdata = {param_value, grad_in, first_moment, second_moment, rate, rate_sat};

  adu_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .qs    (qs)
  );

  adu_back #(.W(W), .F(F)) u_back (
    .clk               (clk),
    .rst               (rst),
    .qs                (qs),
    .pop               (pop),
    .q_param           (rdata[5*W-2:4*W-1]),
    .q_grad            (rdata[4*W-2:3*W-1]),
    .q_m               (rdata[3*W-2:2*W-1]),
    .q_v               (rdata[2*W-2:W]),
    .q_rate            (rdata[W-1:1]),
    .q_sat             (rdata[0]),
    .gradient_scale    (gradient_scale),
    .beta_one          (beta_one),
    .beta_two          (beta_two),
    .epsilon_term      (epsilon_term),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .new_value         (new_value),
    .new_first_moment  (new_first_moment),
    .new_second_moment (new_second_moment),
    .scaled_gradient   (scaled_gradient),
    .saturated         (saturated)
  );

endmodule

/* rtl/adu_front.sv */
// adu_front: input acceptance and the per-step bias-corrected rate unit.
// Keeps beta1^t and beta2^t; uses an iterative square root and divider.
// Depends on adu_pkg.
module adu_front #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   first_of_step,
  output logic                   in_stall,
  input  logic [W-2:0]           learning_rate,
  input  logic [F-1:0]           beta_one,
  input  logic [F-1:0]           beta_two,
  input  adu_pkg::queue_status_t qs,
  output logic                   push,
  output logic [W-2:0]           rate,
  output logic                   rate_sat
);
  import adu_pkg::*;

  localparam int CW = $clog2(W + F);
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  typedef enum logic [2:0] {S_IDLE, S_POW, S_ROOT, S_MUL, S_DIV, S_FIN} state_t;

  state_t          state;
  logic            rate_ready;
  logic [F:0]      b1p, b2p;
  logic [2*F+1:0]  rx;
  logic [F+3:0]    rrem;
  logic [F:0]      rroot;
  logic [W+F-1:0]  dq;
  logic [F+1:0]    drem;
  logic [F:0]      dd;
  logic [CW-1:0]   cnt;
  logic [W-2:0]    crate;
  logic            csat;

  logic [2*F:0]    p1, p2;
  logic [F:0]      b1n, b2n;
  logic [F+3:0]    rsh, rtrial;
  logic            rtake;
  logic [F+1:0]    dsh;
  logic            dtake;
  logic            over;
  logic            accept;

  always_comb begin
    p1     = (2*F+1)'(b1p) * (2*F+1)'(beta_one);
    p2     = (2*F+1)'(b2p) * (2*F+1)'(beta_two);
    b1n    = p1[2*F:F];
    b2n    = p2[2*F:F];
    rsh    = {rrem[F+1:0], rx[2*F+1:2*F]};
    rtrial = {1'b0, rroot, 2'b01};
    rtake  = rsh >= rtrial;
    dsh    = {drem[F:0], dq[W+F-1]};
    dtake  = dsh >= {1'b0, dd};
    over   = |dq[W+F-1:W-1];
  end

  assign in_stall = !(state == S_IDLE && !qs.full && (!first_of_step || rate_ready));
  assign accept   = in_valid && !in_stall;
  assign push     = accept;
  assign rate     = crate;
  assign rate_sat = first_of_step && csat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rate_ready <= 1'b0;
      b1p        <= ONE;
      b2p        <= ONE;
      crate      <= '0;
      csat       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && first_of_step) begin
            rate_ready <= 1'b0;
          end else if (in_valid && first_of_step && !rate_ready) begin
            state <= S_POW;
          end
        end
        S_POW: begin
          b1p   <= b1n;
          b2p   <= b2n;
          rx    <= {1'b0, ONE - b2n, {F{1'b0}}};
          rrem  <= '0;
          rroot <= '0;
          cnt   <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          rx    <= rx << 2;
          rrem  <= rtake ? rsh - rtrial : rsh;
          rroot <= {rroot[F-1:0], rtake};
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(F)) state <= S_MUL;
        end
        S_MUL: begin
          dd   <= ONE - b1p;
          drem <= '0;
          cnt  <= '0;
          // zero bias divisor gives a zero rate
          if (b1p == ONE) begin
            dq    <= '0;
            state <= S_FIN;
          end else begin
            dq    <= (W+F)'(learning_rate) * (W+F)'(rroot);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem  <= dtake ? dsh - {1'b0, dd} : dsh;
          dq    <= {dq[W+F-2:0], dtake};
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(W + F - 1)) state <= S_FIN;
        end
        S_FIN: begin
          crate      <= over ? {(W-1){1'b1}} : dq[W-2:0];
          csat       <= over;
          rate_ready <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/adu_queue.sv */
// adu_queue: four-entry queue between the front and the back datapath.
// Depends on adu_pkg.
module adu_queue #(
  parameter int WIDTH = 159
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   pop,
  output logic [WIDTH-1:0]       rdata,
  output adu_pkg::queue_status_t qs
);
  import adu_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [AW-1:0]    head, tail;
  logic [AW:0]      count;

  assign rdata    = entry[head];
  assign qs.full  = count == (AW+1)'(DEPTH);
  assign qs.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) entry[tail] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop)  head <= head + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !qs.full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !qs.empty)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a transaction");

endmodule

/* rtl/adu_back.sv */
// adu_back: pipelined Adam datapath, one element per cycle unless out_stall holds it.
// Gradient scale, moment updates, pipelined square root and divider.
// Depends on adu_pkg.
module adu_back #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  adu_pkg::queue_status_t qs,
  output logic                   pop,
  input  logic signed [W-1:0]    q_param,
  input  logic signed [W-1:0]    q_grad,
  input  logic signed [W-1:0]    q_m,
  input  logic [W-2:0]           q_v,
  input  logic [W-2:0]           q_rate,
  input  logic                   q_sat,
  input  logic [W-2:0]           gradient_scale,
  input  logic [F-1:0]           beta_one,
  input  logic [F-1:0]           beta_two,
  input  logic [W-2:0]           epsilon_term,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [W-1:0]    new_value,
  output logic signed [W-1:0]    new_first_moment,
  output logic [W-2:0]           new_second_moment,
  output logic signed [W-1:0]    scaled_gradient,
  output logic                   saturated
);
  import adu_pkg::*;

  localparam int MW   = W + F + 3;
  localparam int VW   = 2*W + F + 2;
  localparam int NX   = ((W + F) / 2) * 2;
  localparam int NR   = NX / 2;
  localparam int RW   = NR + 3;
  localparam int DW   = 2*W - 2;
  localparam int DENW = ((NR > W - 1) ? NR : W - 1) + 1;
  localparam logic [F:0] ONE = (F+1)'(1) << F;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] param;
    logic signed [W-1:0] m;
    logic [W-2:0]        v;
    logic [W-2:0]        rate;
    logic                sat;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] param;
    logic signed [W-1:0] mnew;
    logic [W-2:0]        vnew;
    logic signed [W-1:0] g;
    logic                sat;
  } carry_t;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !qs.empty;

  // stage 1: gradient times scale
  logic                  v1;
  in_t                   s1;
  logic signed [2*W-1:0] s1_pg;
  // stage 2: clamp scaled gradient
  logic                  v2;
  in_t                   s2;
  logic signed [W-1:0]   s2_g;
  logic signed [2*W-1:0] gs;
  logic                  g_over;
  // stage 3: moment products
  logic                  v3;
  in_t                   s3;
  logic signed [W-1:0]   s3_g;
  logic signed [W+F:0]   s3_pm1;
  logic signed [W+F+1:0] s3_pm2;
  logic [2*W-1:0]        s3_sqp;
  logic [W+F-2:0]        s3_pv1;
  logic [W-1:0]          gmag;
  // stage 4: first moment result, second moment product
  logic                  v4;
  in_t                   s4;
  logic signed [W-1:0]   s4_g;
  logic signed [W-1:0]   s4_mnew;
  logic [W+F-2:0]        s4_pv1;
  logic [2*W+F:0]        s4_pv2;
  logic signed [MW-1:0]  msum, ms;
  logic                  m_over;
  // stage 5: second moment result
  logic [VW-1:0]         vsum, vf;
  logic                  v_over;
  logic [W-2:0]          vnew;

  always_comb begin
    gs     = s1_pg >>> F;
    g_over = !(&gs[2*W-1:W-1] || ~|gs[2*W-1:W-1]);
    gmag   = s2_g[W-1] ? W'(-s2_g) : W'(s2_g);
    msum   = MW'(s3_pm1) + MW'(s3_pm2);
    ms     = msum >>> F;
    m_over = !(&ms[MW-1:W-1] || ~|ms[MW-1:W-1]);
    vsum   = VW'(s4_pv1) + VW'(s4_pv2);
    vf     = vsum >> F;
    v_over = |vf[VW-1:W-1];
    vnew   = v_over ? {(W-1){1'b1}} : vf[W-2:0];
  end

  // square root and divider pipelines
  logic                  sq_v    [NR+1];
  carry_t                sq_c    [NR+1];
  logic [NX-1:0]         sq_x    [NR+1];
  logic [RW-1:0]         sq_rem  [NR+1];
  logic [NR-1:0]         sq_root [NR+1];
  logic signed [2*W-1:0] sq_prod [NR+1];

  logic                  dv_v    [DW+1];
  carry_t                dv_c    [DW+1];
  logic [DW-1:0]         dv_q    [DW+1];
  logic [DENW-1:0]       dv_rem  [DW+1];
  logic [DENW-1:0]       dv_den  [DW+1];
  logic                  dv_neg  [DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      sq_v[0]  <= 1'b0;
    end else if (adv) begin
      v1       <= pop;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      sq_v[0]  <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= '{param: q_param, m: q_m, v: q_v, rate: q_rate, sat: q_sat};
      s1_pg    <= q_grad * $signed({1'b0, gradient_scale});
      s2       <= '{param: s1.param, m: s1.m, v: s1.v, rate: s1.rate,
                    sat: s1.sat | g_over};
      s2_g     <= g_over ? (gs[2*W-1] ? WMIN : WMAX) : gs[W-1:0];
      s3       <= s2;
      s3_g     <= s2_g;
      s3_pm1   <= s2.m * $signed({1'b0, beta_one});
      s3_pm2   <= s2_g * $signed({1'b0, ONE - {1'b0, beta_one}});
      s3_sqp   <= (2*W)'(gmag) * (2*W)'(gmag);
      s3_pv1   <= (W+F-1)'(s2.v) * (W+F-1)'(beta_two);
      s4       <= '{param: s3.param, m: s3.m, v: s3.v, rate: s3.rate,
                    sat: s3.sat | m_over};
      s4_g     <= s3_g;
      s4_mnew  <= m_over ? (ms[MW-1] ? WMIN : WMAX) : ms[W-1:0];
      s4_pv1   <= s3_pv1;
      s4_pv2   <= (2*W+F+1)'(s3_sqp >> F) * (2*W+F+1)'(ONE - {1'b0, beta_two});
      sq_c[0]    <= '{param: s4.param, mnew: s4_mnew, vnew: vnew, g: s4_g,
                      sat: s4.sat | v_over};
      sq_x[0]    <= NX'(vnew) << F;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_prod[0] <= s4_mnew * $signed({1'b0, s4.rate});
    end
  end

  for (genvar k = 1; k <= NR; k++) begin : g_root
    logic [RW-1:0] sh, trial;
    logic          take;
    always_comb begin
      sh    = {sq_rem[k-1][RW-3:0], sq_x[k-1][NX-1:NX-2]};
      trial = RW'({sq_root[k-1], 2'b01});
      take  = sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (adv) begin
        sq_v[k] <= sq_v[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k]    <= sq_c[k-1];
        sq_x[k]    <= sq_x[k-1] << 2;
        sq_rem[k]  <= take ? sh - trial : sh;
        sq_root[k] <= {sq_root[k-1][NR-2:0], take};
        sq_prod[k] <= sq_prod[k-1];
      end
    end
  end

  // denominator: root plus guard, never zero
  logic [DENW-1:0]       den_sum;
  logic [2*W-1:0]        pmag;
  always_comb begin
    den_sum = DENW'(sq_root[NR]) + DENW'(epsilon_term);
    pmag    = sq_prod[NR][2*W-1] ? (2*W)'(-sq_prod[NR]) : (2*W)'(sq_prod[NR]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[NR];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c[0]   <= sq_c[NR];
      dv_q[0]   <= pmag[DW-1:0];
      dv_rem[0] <= '0;
      dv_den[0] <= (den_sum == '0) ? DENW'(1) : den_sum;
      dv_neg[0] <= sq_prod[NR][2*W-1];
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_div
    logic [DENW:0] dsh, ddif;
    logic          take;
    always_comb begin
      dsh  = {dv_rem[j-1], dv_q[j-1][DW-1]};
      ddif = dsh - {1'b0, dv_den[j-1]};
      take = dsh >= {1'b0, dv_den[j-1]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (adv) begin
        dv_v[j] <= dv_v[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[j]   <= dv_c[j-1];
        dv_q[j]   <= {dv_q[j-1][DW-2:0], take};
        dv_rem[j] <= take ? ddif[DENW-1:0] : dsh[DENW-1:0];
        dv_den[j] <= dv_den[j-1];
        dv_neg[j] <= dv_neg[j-1];
      end
    end
  end

  // final subtract and clamp
  logic signed [2*W-1:0] delta;
  logic signed [2*W:0]   diff;
  logic                  d_over;
  always_comb begin
    delta  = dv_neg[DW] ? -$signed((2*W)'(dv_q[DW])) : $signed((2*W)'(dv_q[DW]));
    diff   = (2*W+1)'(dv_c[DW].param) - (2*W+1)'(delta);
    d_over = !(&diff[2*W:W-1] || ~|diff[2*W:W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_value         <= d_over ? (diff[2*W] ? WMIN : WMAX) : diff[W-1:0];
      new_first_moment  <= dv_c[DW].mnew;
      new_second_moment <= dv_c[DW].vnew;
      scaled_gradient   <= dv_c[DW].g;
      saturated         <= dv_c[DW].sat | d_over;
    end
  end

endmodule

/* bench/adam_update_test.sv */
// adam_update_test: self-checking bench for the fixed-point Adam update block.
// Depends on adu_pkg and adam_update. A queue-fed driver, a checking monitor
// and a cycle-free predictor of the update arithmetic and step state.
module adam_update_test;
  import adu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q     = 64'sd1 << 24;
  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;
  localparam int     DRAIN_WAIT = 200;

  typedef struct {
    logic                first;
    logic signed [31:0]  param;
    logic signed [31:0]  grad;
    logic signed [31:0]  moment1;
    logic [30:0]         moment2;
  } element_t;

  typedef struct {
    logic signed [31:0]  value;
    logic signed [31:0]  moment1;
    logic [30:0]         moment2;
    logic signed [31:0]  grad;
    logic                sat;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic first_of_step = 1'b0;
  logic signed [31:0] param_value = '0, grad_in = '0, first_moment = '0;
  logic [30:0] second_moment = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] new_value, new_first_moment, scaled_gradient;
  logic [30:0] new_second_moment;
  logic saturated;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  adam_update DUT (
    .clk, .rst, .in_valid, .in_stall, .first_of_step, .param_value, .grad_in,
    .first_moment, .second_moment, .out_valid, .out_stall, .new_value,
    .new_first_moment, .new_second_moment, .scaled_gradient, .saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  longint lr = 16777, b1 = 15099494, b2 = 16760439, eps = 1, gscale = 16777216;
  longint b1_pow = ONE_Q, b2_pow = ONE_Q, rate = 0;

  element_t pending_elems[$];
  update_t  expected_updates[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_requests = 0, holds_done = 0, hold_left = 0;
  int err_count = 0, updates_checked = 0, sat_seen = 0, steps_sent = 0;

  function automatic longint int_sqrt(longint x);
    longint res, b;
    res = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : (x > hi) ? hi : x;
  endfunction

  function automatic update_t adam_predict(element_t e);
    update_t u;
    logic sat;
    longint d, s, r, g, m_new, mag, sq, v_full, v_new, den, delta, val;
    sat = 1'b0;
    if (e.first) begin
      b1_pow = (b1_pow * b1) >> 24;
      b2_pow = (b2_pow * b2) >> 24;
      d = ONE_Q - b1_pow;
      s = int_sqrt((ONE_Q - b2_pow) << 24);
      r = (d == 0) ? 0 : (lr * s) / d;
      if (r > WORD_MAX) begin
        r = WORD_MAX;
        sat = 1'b1;
      end
      rate = r;
    end
    g = (longint'(e.grad) * gscale) >>> 24;
    sat |= (clip(g, WORD_MIN, WORD_MAX) != g);
    g = clip(g, WORD_MIN, WORD_MAX);
    m_new = (longint'(e.moment1) * b1 + g * (ONE_Q - b1)) >>> 24;
    sat |= (clip(m_new, WORD_MIN, WORD_MAX) != m_new);
    m_new = clip(m_new, WORD_MIN, WORD_MAX);
    mag = (g < 0) ? -g : g;
    sq = (mag * mag) >> 24;
    v_full = (longint'({1'b0, e.moment2}) * b2 + sq * (ONE_Q - b2)) >> 24;
    v_new = (v_full > WORD_MAX) ? WORD_MAX : v_full;
    sat |= (v_full > WORD_MAX);
    den = int_sqrt(v_new << 24) + eps;
    if (den == 0) den = 1;
    delta = (m_new * rate) / den;
    val = longint'(e.param) - delta;
    sat |= (clip(val, WORD_MIN, WORD_MAX) != val);
    val = clip(val, WORD_MIN, WORD_MAX);
    u.value = val[31:0];
    u.moment1 = m_new[31:0];
    u.moment2 = v_new[30:0];
    u.grad = g[31:0];
    u.sat = sat;
    return u;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    err_count++;
  endtask

  task automatic add_elem(element_t e);
    pending_elems = {pending_elems, e};
  endtask

  // Driver: predict on each accepted transaction, then offer the next element.
  always @(posedge clk) begin
    element_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        e.first = first_of_step;
        e.param = param_value;
        e.grad = grad_in;
        e.moment1 = first_moment;
        e.moment2 = second_moment;
        expected_updates = {expected_updates, adam_predict(e)};
      end
      if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        e = pending_elems.pop_front();
        first_of_step <= e.first;
        param_value <= e.param;
        grad_in <= e.grad;
        first_moment <= e.moment1;
        second_moment <= e.moment2;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles; the monitor only reads hold_left.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      holds_done <= holds_done + 1;
      hold_left <= 400;
    end
  end

  // Monitor: check each accepted result, then pick the next stall value.
  always @(posedge clk) begin
    update_t u;
    if (!rst && out_valid && !out_stall) begin
      if (expected_updates.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        err_count++;
      end else begin
        u = expected_updates.pop_front();
        updates_checked++;
        if (u.sat) sat_seen++;
        if (new_value !== u.value) report_mismatch("new_value", new_value, u.value);
        if (new_first_moment !== u.moment1)
          report_mismatch("new_first_moment", new_first_moment, u.moment1);
        if (new_second_moment !== u.moment2)
          report_mismatch("new_second_moment", {1'b0, new_second_moment}, {1'b0, u.moment2});
        if (scaled_gradient !== u.grad)
          report_mismatch("scaled_gradient", scaled_gradient, u.grad);
        if (saturated !== u.sat) report_mismatch("saturated", {31'b0, saturated}, {31'b0, u.sat});
      end
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE: lr = longint'(data[30:0]);
      CFG_BETA_ONE:      b1 = longint'(data[23:0]);
      CFG_BETA_TWO:      b2 = longint'(data[23:0]);
      CFG_EPSILON:       eps = longint'(data[30:0]);
      CFG_GRAD_SCALE:    gscale = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] l, logic [31:0] p1, logic [31:0] p2,
                         logic [31:0] e, logic [31:0] s);
    write_reg(CFG_LEARNING_RATE, l);
    write_reg(CFG_BETA_ONE, p1);
    write_reg(CFG_BETA_TWO, p2);
    write_reg(CFG_EPSILON, e);
    write_reg(CFG_GRAD_SCALE, s);
  endtask

  // Wait until every queued element is sent and every result is back, then let the pipe settle.
  task automatic drain;
    while (pending_elems.size() > 0 || in_valid || expected_updates.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(33554431)) - 32'sd16777216;
      2: return $signed($urandom_range(2097151)) - 32'sd1048576;
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(255)) - 32'sd128;
    endcase
  endfunction

  function automatic element_t make_elem(logic first);
    element_t e;
    e.first = first;
    e.param = pick_word();
    e.grad = pick_word();
    e.moment1 = pick_word();
    case ($urandom_range(3))
      0: e.moment2 = 31'($urandom);
      1: e.moment2 = 31'($urandom_range(16777216));
      2: e.moment2 = $urandom_range(1) ? 31'h7fffffff : 31'h0;
      default: e.moment2 = 31'($urandom_range(65535));
    endcase
    return e;
  endfunction

  function automatic element_t fixed_elem(logic f, logic signed [31:0] p, logic signed [31:0] g,
                                          logic signed [31:0] m, logic [30:0] v);
    element_t e;
    e.first = f;
    e.param = p;
    e.grad = g;
    e.moment1 = m;
    e.moment2 = v;
    return e;
  endfunction

  // Queue training steps of random length; a few stray step marks act as noise.
  task automatic queue_steps(int count);
    int n, len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(40, 1);
      steps_sent++;
      for (int k = 0; k < len && n < count; k++, n++)
        add_elem(make_elem(k == 0 || $urandom_range(99) < 3));
    end
  endtask

  initial begin
    #20ms;
    $display("adam_update test failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Until the first step the rate is still zero, so parameter values pass through unchanged.
    add_elem(fixed_elem(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff));
    add_elem(fixed_elem(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h0));
    add_elem(fixed_elem(1'b0, 32'sh0, 32'sh0, 32'sh0, 31'h0));
    add_elem(fixed_elem(1'b0, 32'sh01000000, 32'sh00100000, 32'sh00010000, 31'h1000));
    add_elem(fixed_elem(1'b1, 32'sh01000000, 32'shff000000, 32'sh0, 31'h0));
    add_elem(fixed_elem(1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 31'h0));
    add_elem(fixed_elem(1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff));
    add_elem(fixed_elem(1'b1, 32'shffffffff, 32'sh1, 32'shffffffff, 31'h1));
    add_elem(fixed_elem(1'b0, 32'sh0, 32'shffffffff, 32'sh1, 31'h7fffffff));
    queue_steps(200);
    drain();

    // Huge rate with a tiny bias divisor: rate overflow; full gradient scale.
    recv_stall_pct = 0;
    send_idle_pct = 69;
    set_all(32'h7fffffff, 32'hffffff, 32'h0, 32'h1, 32'h7fffffff);
    add_elem(fixed_elem(1'b1, 32'sh0, 32'sh7fffffff, 32'sh7fffffff, 31'h0));
    add_elem(fixed_elem(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h0));
    queue_steps(200);
    drain();

    // Zero scale, largest epsilon, betas at the top of their range.
    send_idle_pct = 0;
    recv_stall_pct = 69;
    set_all(32'd16777, 32'hffffff, 32'hffffff, 32'h7fffffff, 32'h0);
    queue_steps(200);
    drain();

    // Zero epsilon with zero second moment: denominator falls back to one LSB.
    send_idle_pct = 9;
    recv_stall_pct = 9;
    set_all(32'h0, 32'h0, 32'hffffff, 32'h0, 32'h7fffffff);
    add_elem(fixed_elem(1'b1, 32'sh100, 32'sh0, 32'sh01000000, 31'h0));
    add_elem(fixed_elem(1'b0, 32'sh100, 32'sh0, 32'sh80000000, 31'h0));
    drain();
    write_reg(CFG_LEARNING_RATE, 32'h01000000);
    queue_steps(200);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 1) ? 69 : 0;
      recv_stall_pct = (ph == 2) ? 69 : 0;
      set_all($urandom, $urandom_range(16777215), $urandom_range(16777215),
              $urandom_range(32'h7fffffff, 1), $urandom_range(33554432));
      queue_steps(100);
      drain();
    end

    // Long receiver hold-off while the sender keeps offering: fill the queue.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_all(32'd16777, 32'd15099494, 32'd16760439, 32'd1, 32'd16777216);
    hold_requests = 1;
    queue_steps(150);
    drain();

    $display("checked %0d updates over %0d steps (%0d saturated), seven register settings,",
             updates_checked, steps_sent, sat_seen);
    $display("with idle and stall mixes plus a long output hold-off");
    if (err_count == 0) begin
      $display("adam_update test passed");
    end else begin
      $display("adam_update test failed");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/adu_pkg.sv
rtl/adu_front.sv
rtl/adu_queue.sv
rtl/adu_back.sv
rtl/adam_update.sv
bench/adam_update_test.sv
